@@ rtl/kcm_pkg.sv @@
// Shared constants for the key chord matcher: field widths, pattern layout and codes.
package kcm_pkg;

  // Input word fields
  localparam int EVT_W = 5;
  localparam int KEY_W = 10;
  localparam int ACT_W = 2;

  // Result word fields
  localparam int MASK_W = 4;
  localparam int CNT_OUT_W = 4;

  // Pattern register layout: length in the low bits, then key codes in press order
  localparam int LEN_W = 3;
  localparam int KEY_LSB = 3;
  localparam int PAT_W = 43;
  localparam int MAX_PAT = 4;
  localparam int KEY_SEL_W = 2;

  // Configuration port
  localparam int CFG_IDX_W = 2;

  // Event codes
  localparam logic [EVT_W-1:0] EVT_IGNORED = 5'd4;
  localparam logic [KEY_W-1:0] KEY_NONE = 10'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PRESS = 2'd1;

endpackage

@@ rtl/kcm_if.sv @@
// Valid/ready channel interfaces for key events and match results.
interface kcm_in_if import kcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EVT_W-1:0] event_type;
  logic [KEY_W-1:0] key_code;
  logic [ACT_W-1:0] key_action;

  modport source (output valid, event_type, key_code, key_action, input ready);
  modport sink (input valid, event_type, key_code, key_action, output ready);
endinterface

interface kcm_out_if import kcm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MASK_W-1:0]    match_mask;
  logic [CNT_OUT_W-1:0] held_count;
  logic                 overflow;

  modport source (output valid, match_mask, held_count, overflow, input ready);
  modport sink (input valid, match_mask, held_count, overflow, output ready);
endinterface

@@ rtl/kcm_held_list.sv @@
// Held-key list storage: one write port, one read port with registered read data.
module kcm_held_list import kcm_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [KEY_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/kcm_pattern_bank.sv @@
// Chord pattern registers and the key comparators used during the match pass.
module kcm_pattern_bank import kcm_pkg::*; #(
  parameter int NUM_PAT = 4,
  parameter int PAT_KEYS = 4,
  parameter int CNT_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data,
  input  logic [CNT_W-1:0]     total,
  input  logic [KEY_SEL_W-1:0] key_sel,
  input  logic [KEY_W-1:0]     key_data,
  output logic [NUM_PAT-1:0]   len_ok,
  output logic [NUM_PAT-1:0]   key_eq
);

  logic [PAT_W-1:0] pat_r [NUM_PAT];

  // configuration writes; indexes past the bank are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PAT; p++) begin
        pat_r[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PAT; p++) begin
        if (cfg_we && cfg_index == CFG_IDX_W'(p)) begin
          pat_r[p] <= cfg_data;
        end
      end
    end
  end

  // length gate and per-pattern key compare at the current list position
  always_comb begin
    for (int p = 0; p < NUM_PAT; p++) begin
      len_ok[p] = (pat_r[p][LEN_W-1:0] != '0) &&
                  (int'(pat_r[p][LEN_W-1:0]) <= PAT_KEYS) &&
                  (int'(pat_r[p][LEN_W-1:0]) == int'(total));
      key_eq[p] = pat_r[p][KEY_LSB + KEY_W * int'(key_sel) +: KEY_W] == key_data;
    end
  end

endmodule

@@ rtl/key_chord_matcher.sv @@
// Key chord matcher top level: event sequencer, held-list bookkeeping and result register.
//
//   channel  | dir | payload                                | handshake
//   in_ch    | in  | event_type, key_code, key_action       | valid/ready
//   out_ch   | out | match_mask, held_count, overflow       | valid/ready
//   cfg_*    | in  | cfg_index, cfg_data (pattern 0..3)     | cfg_we, no stall
//
// One event at a time. After the accept, a press or repeat sets up the match
// pass, then reads and compares each key (read, compare) over the held list's
// single read port, then loads the result. A release first searches the list
// from the newest end (read, compare per entry) and shifts later entries down
// (read, write per entry). Ignored events are absorbed in the accept cycle.
// Reset (rst_n, synchronous) empties the list and clears the patterns; the list
// storage itself is not cleared. A stalled result holds in the output register;
// the sequencer waits in its final step until that register is free.
module key_chord_matcher import kcm_pkg::*; #(
  parameter int HELD_DEPTH = 8,
  parameter int NUM_PATTERNS = 4,
  parameter int PATTERN_KEYS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  kcm_in_if.sink               in_ch,
  kcm_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data
);

  localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CW = $clog2(HELD_DEPTH + 1);
  localparam int NPS = (NUM_PATTERNS < MAX_PAT) ? NUM_PATTERNS : MAX_PAT;

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_REL_RD     = 8'b0000_0010,
    ST_REL_CMP    = 8'b0000_0100,
    ST_SHF_RD     = 8'b0000_1000,
    ST_SHF_WR     = 8'b0001_0000,
    ST_MATCH_INIT = 8'b0010_0000,
    ST_MATCH_RD   = 8'b0100_0000,
    ST_MATCH_CMP  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     total_r, total_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [KEY_W-1:0]  code_r, code_nxt;
  logic              over_r, over_nxt;
  logic [NPS-1:0]    cand_r, cand_nxt;

  logic                 out_valid_r;
  logic [MASK_W-1:0]    out_mask_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic                 out_over_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [KEY_W-1:0]  mem_wdata;
  logic [KEY_W-1:0]  mem_rdata;
  logic [NPS-1:0]    len_ok;
  logic [NPS-1:0]    key_eq;

  logic              in_fire;
  logic              ignored;
  logic              out_free;
  logic [CW-1:0]     idx_ext;
  logic [CW-1:0]     total_dec;

  assign in_ch.ready = (state_r == ST_IDLE) && !done_r;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign ignored = (in_ch.event_type == EVT_IGNORED) || (in_ch.key_code == KEY_NONE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_ext = CW'(idx_r);
  assign total_dec = total_r - CW'(1);

  // held list storage
  kcm_held_list #(
    .DEPTH (HELD_DEPTH),
    .AW    (AW)
  ) u_held (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (idx_r),
    .rd_data (mem_rdata)
  );

  // pattern registers and comparators
  kcm_pattern_bank #(
    .NUM_PAT  (NPS),
    .PAT_KEYS (PATTERN_KEYS),
    .CNT_W    (CW)
  ) u_pat (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .total     (total_r),
    .key_sel   (KEY_SEL_W'(idx_r)),
    .key_data  (mem_rdata),
    .len_ok    (len_ok),
    .key_eq    (key_eq)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    code_nxt  = code_r;
    over_nxt  = over_r;
    cand_nxt  = cand_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = mem_rdata;

    if (done_r) begin
      // result waits for the output register
      if (out_free) begin
        done_nxt = 1'b0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && !ignored) begin
            code_nxt  = in_ch.key_code;
            over_nxt  = 1'b0;
            state_nxt = ST_MATCH_INIT;
            if (in_ch.key_action == ACT_RELEASE) begin
              if (total_r != '0) begin
                idx_nxt   = total_dec[AW-1:0];
                state_nxt = ST_REL_RD;
              end
            end else if (in_ch.key_action == ACT_PRESS) begin
              if (total_r >= CW'(HELD_DEPTH)) begin
                over_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = total_r[AW-1:0];
                mem_wdata = in_ch.key_code;
                total_nxt = total_r + CW'(1);
              end
            end
          end
        end
        ST_REL_RD: begin
          state_nxt = ST_REL_CMP;
        end
        // search from the newest entry down
        ST_REL_CMP: begin
          if (mem_rdata == code_r) begin
            if (idx_ext + CW'(1) < total_r) begin
              idx_nxt   = idx_r + AW'(1);
              state_nxt = ST_SHF_RD;
            end else begin
              total_nxt = total_dec;
              state_nxt = ST_MATCH_INIT;
            end
          end else if (idx_r == '0) begin
            state_nxt = ST_MATCH_INIT;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = ST_REL_RD;
          end
        end
        // idx_r points at the entry to move down one place
        ST_SHF_RD: begin
          state_nxt = ST_SHF_WR;
        end
        ST_SHF_WR: begin
          mem_we    = 1'b1;
          mem_waddr = idx_r - AW'(1);
          mem_wdata = mem_rdata;
          if (idx_ext + CW'(1) < total_r) begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_SHF_RD;
          end else begin
            total_nxt = total_dec;
            state_nxt = ST_MATCH_INIT;
          end
        end
        ST_MATCH_INIT: begin
          cand_nxt = len_ok;
          idx_nxt  = '0;
          if (len_ok == '0) begin
            state_nxt = ST_IDLE;
            done_nxt  = 1'b1;
          end else begin
            state_nxt = ST_MATCH_RD;
          end
        end
        ST_MATCH_RD: begin
          state_nxt = ST_MATCH_CMP;
        end
        ST_MATCH_CMP: begin
          cand_nxt = cand_r & key_eq;
          if (idx_ext + CW'(1) == total_r) begin
            state_nxt = ST_IDLE;
            done_nxt  = 1'b1;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_MATCH_RD;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // control and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    code_r <= code_nxt;
    over_r <= over_nxt;
    cand_r <= cand_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_r && out_free) begin
      out_mask_r  <= MASK_W'(cand_r);
      out_count_r <= CNT_OUT_W'(total_r);
      out_over_r  <= over_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.match_mask = out_mask_r;
  assign out_ch.held_count = out_count_r;
  assign out_ch.overflow   = out_over_r;

endmodule
